[src/msm_pkg.sv]
// Shared constants and control types for the square matrix multiply block.
package msm_pkg;

   localparam int MAX_DIM_DEFAULT = 8;
   localparam int ELEM_W = 32;
   localparam int PROD_W = 64;
   localparam int ACC_W = 67;
   localparam int IDX_W = 3;
   localparam int DIM_W = 4;
   localparam int COUNT_W = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic             wr_en;
      logic             rd_en;
      logic             first;
      logic             last;
      logic             final_flag;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
      logic result_load;
   } status_type;

endpackage

[src/msm_if.sv]
// Request, response and register-write channel interfaces.
interface msm_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [msm_pkg::ELEM_W-1:0]  element;

   modport source (output valid, output element, input ready);
   modport sink (input valid, input element, output ready);
endinterface

interface msm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [msm_pkg::PROD_W-1:0]  product_value;
   logic [msm_pkg::IDX_W-1:0]          row_index;
   logic [msm_pkg::IDX_W-1:0]          column_index;
   logic                               final_flag;

   modport source (output valid, output product_value, output row_index,
                   output column_index, output final_flag, input ready);
   modport sink (input valid, input product_value, input row_index,
                 input column_index, input final_flag, output ready);
endinterface

interface msm_csr_if;
   logic                        valid;
   logic                        ready;
   logic [msm_pkg::DIM_W-1:0]   dimension;

   modport source (output valid, output dimension, input ready);
   modport sink (input valid, input dimension, output ready);
endinterface

[src/matrix_square_multiply_top.sv]
// Top level of the square matrix multiply block, C = A * A in fixed point.
//
// Load n*n Q16.16 elements of A in row-major order, one per cycle while the block
// is loading (req.ready high); the dimension register (1..MAX_DIM, reset MAX_DIM,
// 0 reads as 1, larger values as MAX_DIM) may be written between requests. After
// the last element the block issues one response per element of C, row-major,
// each a saturated Q32.32 value with its row, column and a final marker on the
// last one. A single multiply-accumulate unit, fed by a two-read-port element
// store, takes one term per cycle; each result passes the read, multiply,
// accumulate and result stages, and the next element of C starts only once the
// previous response is taken. Requests are not taken while C is being computed.
module matrix_square_multiply_top #(
   parameter int MAX_DIM = msm_pkg::MAX_DIM_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   msm_req_if.sink   req,
   msm_rsp_if.source rsp,
   msm_csr_if.sink   csr
);

   localparam int Depth = MAX_DIM * MAX_DIM;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

   msm_pkg::cmd_type    cmd;
   msm_pkg::status_type status;
   logic [AddrW-1:0]    wr_addr;
   logic [AddrW-1:0]    rd_addr_a;
   logic [AddrW-1:0]    rd_addr_b;

   msm_ctrl #(
      .MAX_DIM (MAX_DIM),
      .DEPTH   (Depth),
      .ADDR_W  (AddrW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr       (csr),
      .status    (status),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b)
   );

   msm_datapath #(
      .MAX_DIM (MAX_DIM),
      .DEPTH   (Depth),
      .ADDR_W  (AddrW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .wr_data   (req.element),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .status    (status),
      .rsp       (rsp)
   );

endmodule

[src/msm_ram.sv]
// Generic RAM with one write port and two registered read ports.
module msm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   output logic [WIDTH-1:0]  rd_data_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

[src/msm_datapath.sv]
// Element store, multiply-accumulate pipeline and saturating result register.
module msm_datapath #(
   parameter int MAX_DIM = msm_pkg::MAX_DIM_DEFAULT,
   parameter int DEPTH = MAX_DIM * MAX_DIM,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  msm_pkg::cmd_type                   cmd,
   input  logic [ADDR_W-1:0]                  wr_addr,
   input  logic signed [msm_pkg::ELEM_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]                  rd_addr_a,
   input  logic [ADDR_W-1:0]                  rd_addr_b,
   output msm_pkg::status_type                status,
   msm_rsp_if.source                          rsp
);

   logic [msm_pkg::ELEM_W-1:0]        rd_a;
   logic [msm_pkg::ELEM_W-1:0]        rd_b;
   msm_pkg::cmd_type                  p1_ff;
   msm_pkg::cmd_type                  p2_ff;
   msm_pkg::cmd_type                  p3_ff;
   logic signed [msm_pkg::PROD_W-1:0] product_ff;
   logic signed [msm_pkg::ACC_W-1:0]  acc_ff;
   logic signed [msm_pkg::ACC_W-1:0]  product_ext;
   logic signed [msm_pkg::ACC_W-1:0]  acc_in;
   logic signed [msm_pkg::PROD_W-1:0] sat_value;
   logic                              rsp_valid_ff;
   logic signed [msm_pkg::PROD_W-1:0] rsp_value_ff;
   logic [msm_pkg::IDX_W-1:0]         rsp_row_ff;
   logic [msm_pkg::IDX_W-1:0]         rsp_col_ff;
   logic                              rsp_final_ff;
   logic                              load_result;

   msm_ram #(
      .WIDTH  (msm_pkg::ELEM_W),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (cmd.wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_b)
   );

   assign product_ext = {{(msm_pkg::ACC_W - msm_pkg::PROD_W){product_ff[msm_pkg::PROD_W-1]}},
                         product_ff};
   assign acc_in = p2_ff.first ? product_ext : acc_ff + product_ext;
   assign load_result = p3_ff.rd_en && p3_ff.last;

   always_comb begin
      if (acc_ff[msm_pkg::ACC_W-1:msm_pkg::PROD_W-1] == '0 ||
          acc_ff[msm_pkg::ACC_W-1:msm_pkg::PROD_W-1] == '1) begin
         sat_value = acc_ff[msm_pkg::PROD_W-1:0];
      end else if (acc_ff[msm_pkg::ACC_W-1]) begin
         sat_value = {1'b1, {(msm_pkg::PROD_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(msm_pkg::PROD_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= '0;
         p2_ff <= '0;
         p3_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_ff <= cmd;
         p2_ff <= p1_ff;
         p3_ff <= p2_ff;
         if (load_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      product_ff <= signed'(rd_a) * signed'(rd_b);
      if (p2_ff.rd_en) begin
         acc_ff <= acc_in;
      end
      if (load_result) begin
         rsp_value_ff <= sat_value;
         rsp_row_ff <= p3_ff.row;
         rsp_col_ff <= p3_ff.col;
         rsp_final_ff <= p3_ff.final_flag;
      end
   end

   assign status.out_busy = rsp_valid_ff;
   assign status.result_load = load_result;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.product_value = rsp_value_ff;
   assign rsp.row_index = rsp_row_ff;
   assign rsp.column_index = rsp_col_ff;
   assign rsp.final_flag = rsp_final_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_result |-> !rsp_valid_ff)
      else $error("result loaded over a pending response");

endmodule

[src/msm_ctrl.sv]
// Controller: load counting, dimension register and element/term sequencing.
module msm_ctrl #(
   parameter int MAX_DIM = msm_pkg::MAX_DIM_DEFAULT,
   parameter int DEPTH = MAX_DIM * MAX_DIM,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   msm_req_if.sink              req,
   msm_csr_if.sink              csr,
   input  msm_pkg::status_type  status,
   output msm_pkg::cmd_type     cmd,
   output logic [ADDR_W-1:0]    wr_addr,
   output logic [ADDR_W-1:0]    rd_addr_a,
   output logic [ADDR_W-1:0]    rd_addr_b
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_WAIT,
      ST_RUN,
      ST_DRAIN
   } state_type;

   localparam logic [msm_pkg::DIM_W-1:0]   DimMax = msm_pkg::DIM_W'(MAX_DIM);
   localparam logic [msm_pkg::COUNT_W-1:0] DepthCount = msm_pkg::COUNT_W'(DEPTH);

   state_type                      state_ff, state_in;
   logic [msm_pkg::DIM_W-1:0]      dimension_ff, dimension_in;
   logic [msm_pkg::DIM_W-1:0]      n_ff, n_in;
   logic [msm_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [msm_pkg::IDX_W-1:0]      i_ff, i_in;
   logic [msm_pkg::IDX_W-1:0]      j_ff, j_in;
   logic [msm_pkg::IDX_W-1:0]      k_ff, k_in;
   logic [ADDR_W-1:0]              row_base_ff, row_base_in;
   logic [ADDR_W-1:0]              a_addr_ff, a_addr_in;
   logic [ADDR_W-1:0]              b_addr_ff, b_addr_in;

   logic [msm_pkg::DIM_W-1:0]      n_eff;
   logic [msm_pkg::COUNT_W-1:0]    count_next;
   logic [msm_pkg::COUNT_W-1:0]    total;
   logic                           accept;
   logic                           last_k;
   logic                           last_j;
   logic                           final_elem;

   always_comb begin
      if (dimension_ff == '0) begin
         n_eff = msm_pkg::DIM_W'(1);
      end else if (dimension_ff > DimMax) begin
         n_eff = DimMax;
      end else begin
         n_eff = dimension_ff;
      end
   end

   assign total = msm_pkg::COUNT_W'(n_eff) * msm_pkg::COUNT_W'(n_eff);
   assign count_next = (count_ff == msm_pkg::COUNT_MAX) ? count_ff
                                                        : count_ff + 1'b1;
   assign req.ready = (state_ff == ST_LOAD);
   assign csr.ready = 1'b1;
   assign accept = req.valid && req.ready;
   assign last_k = ({1'b0, k_ff} == n_ff - 1'b1);
   assign last_j = ({1'b0, j_ff} == n_ff - 1'b1);
   assign final_elem = last_j && ({1'b0, i_ff} == n_ff - 1'b1);

   assign cmd.wr_en = accept && (count_ff < DepthCount);
   assign cmd.rd_en = (state_ff == ST_RUN);
   assign cmd.first = (k_ff == '0);
   assign cmd.last = last_k;
   assign cmd.final_flag = final_elem;
   assign cmd.row = i_ff;
   assign cmd.col = j_ff;
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign rd_addr_a = a_addr_ff;
   assign rd_addr_b = b_addr_ff;

   always_comb begin
      state_in = state_ff;
      dimension_in = csr.valid ? csr.dimension : dimension_ff;
      n_in = n_ff;
      count_in = count_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      row_base_in = row_base_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (count_next >= total) begin
                  count_in = '0;
                  n_in = n_eff;
                  i_in = '0;
                  j_in = '0;
                  row_base_in = '0;
                  state_in = ST_WAIT;
               end else begin
                  count_in = count_next;
               end
            end
         end
         ST_WAIT: begin
            if (!status.out_busy) begin
               k_in = '0;
               a_addr_in = row_base_ff;
               b_addr_in = ADDR_W'(j_ff);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            k_in = k_ff + 1'b1;
            a_addr_in = a_addr_ff + 1'b1;
            b_addr_in = b_addr_ff + ADDR_W'(n_ff);
            if (last_k) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.result_load) begin
               if (final_elem) begin
                  state_in = ST_LOAD;
               end else if (last_j) begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
                  row_base_in = row_base_ff + ADDR_W'(n_ff);
                  state_in = ST_WAIT;
               end else begin
                  j_in = j_ff + 1'b1;
                  state_in = ST_WAIT;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         dimension_ff <= DimMax;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         dimension_ff <= dimension_in;
         count_ff <= count_in;
      end
      n_ff <= n_in;
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      row_base_ff <= row_base_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
   end

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !status.out_busy)
      else $error("term issued while a response is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCount)
      else $error("load count beyond store depth");

   a_drain_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && !status.result_load) |=> state_ff == ST_DRAIN)
      else $error("left drain without a result");

endmodule

[tb/tb.sv]
// Self-checking bench for the square matrix multiply block: loads A, checks every C = A * A
`timescale 1ns / 1ps

module tb;

   localparam int MAX_DIM_DEFAULT = msm_pkg::MAX_DIM_DEFAULT;
   localparam int ELEM_W = msm_pkg::ELEM_W;
   localparam int PROD_W = msm_pkg::PROD_W;
   localparam int IDX_W = msm_pkg::IDX_W;
   localparam int DIM_W = msm_pkg::DIM_W;

   localparam int SIDE_MAX = MAX_DIM_DEFAULT;
   localparam int STORE_DEPTH = SIDE_MAX * SIDE_MAX;
   localparam int GAP_MAX = 11;
   localparam int SETTLE_CYCLES = 32;
   localparam int TAIL_CYCLES = 64;
   localparam int HOLD_CYCLES = 400;
   localparam int ITEM_TARGET = 480;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 30;

   localparam logic [ELEM_W-1:0] Q_MIN = 32'h8000_0000;
   localparam logic [ELEM_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] Q_ZERO = 32'h0000_0000;
   localparam logic [ELEM_W-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;
   localparam logic [ELEM_W-1:0] Q_ONE = 32'h0001_0000;
   localparam logic [ELEM_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
   localparam logic [ELEM_W-1:0] Q_TWO = 32'h0002_0000;
   localparam logic [ELEM_W-1:0] Q_HALF = 32'h0000_8000;
   localparam logic [ELEM_W-1:0] Q_NEG_HALF = 32'hFFFF_8000;
   localparam logic [ELEM_W-1:0] Q_NEG_THREE = 32'hFFFD_0000;

   localparam logic [PROD_W-1:0] PROD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [PROD_W-1:0] PROD_MIN = 64'h8000_0000_0000_0000;

   typedef enum int {FILL_FULL, FILL_UNIT, FILL_CORNER, FILL_MIXED} fill_kind_type;

   typedef struct {
      logic [PROD_W-1:0] value;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic              last;
   } c_element_type;

   logic clock = 1'b0;
   logic reset;

   msm_req_if req_ch ();
   msm_rsp_if rsp_ch ();
   msm_csr_if csr_ch ();

   matrix_square_multiply_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   logic [ELEM_W-1:0] a_store [STORE_DEPTH];
   int unsigned       load_cnt;
   logic [DIM_W-1:0]  dim_reg;
   c_element_type     expected_products [$];
   c_element_type     rsp_want;

   int               cycle_count;
   int               mismatch_count;
   int               items_sent;
   int               results_seen;
   int               matrices_done;
   int               saturated_seen;
   logic [SIDE_MAX:1] sides_done;
   bit               req_gaps_on;
   bit               rsp_gaps_on;
   int               rsp_stall;
   int               rsp_hold_left;

   always #2 clock = ~clock;

   function automatic int unsigned side_in_use();
      if (dim_reg == 0) return 1;
      if (dim_reg > SIDE_MAX) return SIDE_MAX;
      return dim_reg;
   endfunction

   function automatic logic [PROD_W-1:0] square_dot(int unsigned n, int unsigned i,
                                                    int unsigned j);
      logic signed [PROD_W+7:0] acc;
      logic signed [PROD_W+7:0] term;
      longint pa;
      longint pb;
      acc = '0;
      for (int unsigned k = 0; k < n; k++) begin
         pa = longint'($signed(a_store[(i * n + k) % STORE_DEPTH]));
         pb = longint'($signed(a_store[(k * n + j) % STORE_DEPTH]));
         term = pa * pb;
         acc = acc + term;
      end
      if (acc[PROD_W+7:PROD_W-1] == {9{acc[PROD_W+7]}}) return acc[PROD_W-1:0];
      if (acc[PROD_W+7]) return PROD_MIN;
      return PROD_MAX;
   endfunction

   function automatic void accept_element(logic [ELEM_W-1:0] value);
      int unsigned   n;
      c_element_type c;
      n = side_in_use();
      if (load_cnt < STORE_DEPTH) a_store[load_cnt] = value;
      if (load_cnt < 127) load_cnt++;
      if (load_cnt >= n * n) begin
         load_cnt = 0;
         matrices_done++;
         sides_done[n] = 1'b1;
         for (int unsigned i = 0; i < n; i++) begin
            for (int unsigned j = 0; j < n; j++) begin
               c.value = square_dot(n, i, j);
               c.row = IDX_W'(i);
               c.col = IDX_W'(j);
               c.last = (i == n - 1) && (j == n - 1);
               expected_products.push_back(c);
            end
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("MISMATCH cycle %0d: %s", cycle_count, what);
   endtask

   task automatic send_element(input logic [ELEM_W-1:0] value);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.element <= value;
      do @(posedge clock); while (!req_ch.ready);
      accept_element(value);
      items_sent++;
   endtask

   task automatic release_request();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic settle_block();
      release_request();
      while (expected_products.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dimension(input logic [DIM_W-1:0] value);
      settle_block();
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.dimension <= value;
      do @(posedge clock); while (!csr_ch.ready);
      dim_reg = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [ELEM_W-1:0] draw_element(fill_kind_type kind);
      fill_kind_type pick;
      pick = kind;
      if (pick == FILL_MIXED) pick = ($urandom_range(0, 1) == 0) ? FILL_FULL : FILL_CORNER;
      case (pick)
         FILL_UNIT: return ELEM_W'($urandom_range(0, 2 * Q_ONE) - Q_ONE);
         FILL_CORNER: begin
            case ($urandom_range(0, 5))
               0: return Q_MIN;
               1: return Q_MAX;
               2: return Q_ZERO;
               3: return Q_NEG_LSB;
               4: return Q_ONE;
               default: return Q_NEG_ONE;
            endcase
         end
         default: return ELEM_W'($urandom());
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] draw_dimension();
      int r;
      logic [DIM_W-1:0] v;
      r = $urandom_range(0, 9);
      if (r < 6) return DIM_W'($urandom_range(1, 4));
      if (r < 9) return DIM_W'($urandom_range(5, SIDE_MAX));
      v = DIM_W'($urandom_range(SIDE_MAX, 15));
      if (v == SIDE_MAX) v = '0;
      return v;
   endfunction

   task automatic send_matrix(input fill_kind_type kind);
      do send_element(draw_element(kind)); while (load_cnt != 0);
   endtask

   task automatic test_reset_dimension();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      send_matrix(FILL_FULL);
      settle_block();
   endtask

   task automatic test_directed_corners();
      logic [ELEM_W-1:0] singles [6];
      logic [ELEM_W-1:0] mixed_square [4];
      logic [ELEM_W-1:0] negative_sum [9];
      singles = '{Q_MIN, Q_MAX, Q_ZERO, Q_NEG_LSB, Q_ONE, Q_NEG_HALF};
      mixed_square = '{Q_ONE, Q_TWO, Q_NEG_THREE, Q_HALF};
      negative_sum = '{Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX};
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b0;
      write_dimension(1);
      foreach (singles[i]) send_element(singles[i]);
      write_dimension(2);
      repeat (4) send_element(Q_MIN);
      foreach (mixed_square[i]) send_element(mixed_square[i]);
      write_dimension(3);
      foreach (negative_sum[i]) send_element(negative_sum[i]);
      settle_block();
   endtask

   task automatic test_dimension_range();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b1;
      write_dimension(4'h0);
      repeat (2) send_element(draw_element(FILL_FULL));
      write_dimension(4'hF);
      send_matrix(FILL_FULL);
      settle_block();
   endtask

   task automatic test_mid_load_resize();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      write_dimension(3);
      repeat (5) send_element(draw_element(FILL_MIXED));
      write_dimension(2);
      send_element(draw_element(FILL_MIXED));
      repeat (2) send_element(draw_element(FILL_UNIT));
      write_dimension(4);
      send_matrix(FILL_UNIT);
      settle_block();
   endtask

   task automatic test_output_backpressure();
      write_dimension(4);
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      @(posedge clock);
      rsp_hold_left = HOLD_CYCLES;
      repeat (3) send_matrix(FILL_MIXED);
      settle_block();
   endtask

   task automatic test_random_matrices();
      fill_kind_type kind;
      int unsigned   n;
      while (items_sent < ITEM_TARGET) begin
         req_gaps_on = $urandom_range(0, 3) != 0;
         rsp_gaps_on = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 2) == 0) write_dimension(draw_dimension());
         kind = fill_kind_type'($urandom_range(FILL_FULL, FILL_MIXED));
         n = side_in_use();
         if ($urandom_range(0, 9) == 0 && n > 1) begin
            repeat ($urandom_range(1, n * n - 1)) send_element(draw_element(kind));
            write_dimension(draw_dimension());
         end
         send_matrix(kind);
         if ($urandom_range(0, 4) == 0) settle_block();
      end
      settle_block();
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at cycle limit %0d with %0d responses outstanding",
                  CYCLE_LIMIT, expected_products.size());
         $display("tb failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold_left--;
      end else if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         rsp_stall = rsp_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
         if (rsp_ch.product_value === PROD_MAX || rsp_ch.product_value === PROD_MIN)
            saturated_seen++;
         if (expected_products.size() == 0) begin
            report_mismatch($sformatf("unexpected response value %h row %0d col %0d",
                                      rsp_ch.product_value, rsp_ch.row_index,
                                      rsp_ch.column_index));
         end else begin
            rsp_want = expected_products.pop_front();
            if (rsp_ch.product_value !== rsp_want.value)
               report_mismatch($sformatf("value %h, want %h at row %0d col %0d",
                                         rsp_ch.product_value, rsp_want.value,
                                         rsp_want.row, rsp_want.col));
            if (rsp_ch.row_index !== rsp_want.row)
               report_mismatch($sformatf("row %0d, want %0d", rsp_ch.row_index,
                                         rsp_want.row));
            if (rsp_ch.column_index !== rsp_want.col)
               report_mismatch($sformatf("column %0d, want %0d", rsp_ch.column_index,
                                         rsp_want.col));
            if (rsp_ch.final_flag !== rsp_want.last)
               report_mismatch($sformatf("final flag %b, want %b at row %0d col %0d",
                                         rsp_ch.final_flag, rsp_want.last,
                                         rsp_want.row, rsp_want.col));
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.element = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.dimension = '0;
      load_cnt = 0;
      dim_reg = DIM_W'(SIDE_MAX);
      foreach (a_store[i]) a_store[i] = '0;
      cycle_count = 0;
      mismatch_count = 0;
      items_sent = 0;
      results_seen = 0;
      matrices_done = 0;
      saturated_seen = 0;
      sides_done = '0;
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      rsp_stall = 0;
      rsp_hold_left = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_dimension();
      test_directed_corners();
      test_dimension_range();
      test_mid_load_resize();
      test_output_backpressure();
      test_random_matrices();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d elements forming %0d matrices, checked %0d products",
               items_sent, matrices_done, results_seen);
      $display("Sides exercised (bit per side 8..1): %b, saturated products: %0d",
               sides_done, saturated_seen);
      if (mismatch_count == 0 && expected_products.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
